// ===== design/rse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
// No dependencies; every other design file imports this package.
package rse_pkg;

    localparam int DATA_W          = 32;
    localparam int NUM_W           = 31;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int DIV_CNT_W       = $clog2(DATA_W + 1);

    localparam logic KIND_NUM = 1'b0;
    localparam logic KIND_OP  = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_DEPTH   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_FIN
    } state_t;

    typedef struct packed {
        logic             kind;
        logic [NUM_W-1:0] number;
        logic [1:0]       op;
        logic             last;
    } rse_token_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [2:0]               status;
    } rse_result_t;

    // Shift control for one stack cell
    typedef struct packed {
        logic load_above;
        logic load_below;
    } rse_cell_ctl_t;

endpackage

// ===== design/rse_cell.sv =====
// One entry of the shifting operand stack.
// Depends on rse_pkg for the cell control struct.
module rse_cell #(
    parameter int W = rse_pkg::DATA_W
) (
    input  logic                  aclk,
    input  rse_pkg::rse_cell_ctl_t ctl,
    input  logic [W-1:0]          above_in,
    input  logic [W-1:0]          below_in,
    output logic [W-1:0]          data_out
);
    import rse_pkg::*;

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    // Take the neighbor's entry on a shift, hold otherwise
    always_comb begin
        data_next = data_reg;
        if (ctl.load_above) begin
            data_next = above_in;
        end else if (ctl.load_below) begin
            data_next = below_in;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

// ===== design/rse_div.sv =====
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on rse_pkg for widths.
module rse_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rse_pkg::DATA_W-1:0] dividend,
    input  logic [rse_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [rse_pkg::DATA_W-1:0] quotient
);
    import rse_pkg::*;

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 neg_reg,  neg_next;
    logic [DATA_W-1:0]    rem_reg,  rem_next;
    logic [DATA_W-1:0]    q_reg,    q_next;
    logic [DATA_W-1:0]    den_reg,  den_next;
    logic [DATA_W:0]      rem_shift;
    logic [DATA_W:0]      rem_sub;

    // Partial remainder stays below the divisor magnitude, so it fits in DATA_W bits
    assign rem_shift = {rem_reg, q_reg[DATA_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    // Load magnitudes on start, then one restoring step per cycle
    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(DATA_W);
            neg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rem_next = '0;
            q_next   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
        end else if (run_reg) begin
            if (!rem_sub[DATA_W]) begin
                rem_next = rem_sub[DATA_W-1:0];
                q_next   = {q_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DATA_W-1:0];
                q_next   = {q_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

// ===== design/rpn_stack_evaluator.sv =====
// Postfix (RPN) evaluator: a row of shifting stack cells, an ALU and a serial divider.
// Depends on rse_pkg, rse_cell and rse_div.
//
// One token word is taken at a time, the next only in the idle state. A number passes
// the EXEC and FIN states, an add, subtract or multiply passes EXEC, WRITE and FIN,
// and a divide also waits in DIV while the divider produces one quotient bit per cycle.
// The stack is a chain of STACK_DEPTH cells with the top entry in the first cell, so a
// push or pop is one shift of the whole chain. The result word of a last token sits in
// an output register; the next token is taken while it waits, and only a further last
// token stalls until it is taken. Value is zero whenever status is not ok.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rse_pkg::rse_token_t  s_token,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rse_pkg::rse_result_t m_result
);
    import rse_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);

    state_t            state_reg, state_next;
    rse_token_t        tok_reg,   tok_next;
    logic [DW-1:0]     depth_reg, depth_next;
    status_t           err_reg,   err_next;
    logic [DATA_W-1:0] res_reg,   res_next;
    logic              m_valid_reg, m_valid_next;
    rse_result_t       m_result_reg, m_result_next;

    logic [DATA_W-1:0] cell_q [STACK_DEPTH];
    rse_cell_ctl_t     cell_ctl [STACK_DEPTH];
    logic [DATA_W-1:0] feed;
    logic [DATA_W-1:0] rhs, lhs;
    logic [DATA_W-1:0] alu;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    // Control decoded from the state
    logic push_en, pop_en, div_start, res_from_alu, res_from_div;
    logic set_err, emit, finish;
    status_t err_val;
    logic out_free;

    assign rhs      = cell_q[0];
    assign lhs      = cell_q[1];
    assign out_free = !m_valid_reg || m_ready;

    // Operand stack chain
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] above, below;
        if (i == 0) begin : g_top
            assign above = feed;
        end else begin : g_mid
            assign above = cell_q[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_bot
            assign below = cell_q[i];
        end else begin : g_inner
            assign below = cell_q[i+1];
        end
        assign cell_ctl[i].load_above = push_en || (pop_en && (i == 0));
        assign cell_ctl[i].load_below = pop_en && (i != 0);
        rse_cell #(.W(DATA_W)) u_cell (
            .aclk     (aclk),
            .ctl      (cell_ctl[i]),
            .above_in (above),
            .below_in (below),
            .data_out (cell_q[i])
        );
    end

    rse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lhs),
        .divisor  (rhs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Push a literal, or write the combined result back over the old top
    assign feed = push_en ? {1'b0, tok_reg.number} : res_reg;

    // Add, subtract, multiply with wrap
    always_comb begin
        case (tok_reg.op)
            OP_ADD:  alu = lhs + rhs;
            OP_SUB:  alu = lhs - rhs;
            default: alu = DATA_W'(lhs * rhs);
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (err_reg != ST_OK || tok_reg.kind == KIND_NUM) begin
                    state_next = S_FIN;
                end else if (depth_reg < DW'(2)) begin
                    state_next = S_FIN;
                end else if (tok_reg.op == OP_DIV) begin
                    state_next = (rhs == '0) ? S_FIN : S_DIV;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_DIV: begin
                if (div_done) state_next = S_WRITE;
            end
            S_WRITE: state_next = S_FIN;
            S_FIN: begin
                if (!tok_reg.last || out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready      = 1'b0;
        push_en      = 1'b0;
        pop_en       = 1'b0;
        div_start    = 1'b0;
        res_from_alu = 1'b0;
        res_from_div = 1'b0;
        set_err      = 1'b0;
        err_val      = ST_OK;
        emit         = 1'b0;
        finish       = 1'b0;
        unique case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_EXEC: begin
                if (err_reg == ST_OK) begin
                    if (tok_reg.kind == KIND_NUM) begin
                        if (depth_reg == DW'(STACK_DEPTH)) begin
                            set_err = 1'b1;
                            err_val = ST_OVER;
                        end else begin
                            push_en = 1'b1;
                        end
                    end else if (depth_reg < DW'(2)) begin
                        set_err = 1'b1;
                        err_val = ST_UNDER;
                    end else if (tok_reg.op == OP_DIV) begin
                        if (rhs == '0) begin
                            set_err = 1'b1;
                            err_val = ST_DIVZERO;
                        end else begin
                            div_start = 1'b1;
                        end
                    end else begin
                        res_from_alu = 1'b1;
                    end
                end
            end
            S_DIV:   res_from_div = div_done;
            S_WRITE: pop_en = 1'b1;
            S_FIN: begin
                if (tok_reg.last && out_free) begin
                    emit   = 1'b1;
                    finish = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Datapath and bookkeeping
    always_comb begin
        tok_next      = tok_reg;
        depth_next    = depth_reg;
        err_next      = err_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        if (s_valid && s_ready) tok_next = s_token;
        if (push_en) depth_next = depth_reg + 1'b1;
        if (pop_en)  depth_next = depth_reg - 1'b1;
        if (set_err) err_next = err_val;
        if (res_from_alu) res_next = alu;
        if (res_from_div) res_next = div_q;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (emit) begin
            m_valid_next = 1'b1;
            if (err_reg != ST_OK) begin
                m_result_next.value  = '0;
                m_result_next.status = err_reg;
            end else if (depth_reg != DW'(1)) begin
                m_result_next.value  = '0;
                m_result_next.status = ST_DEPTH;
            end else begin
                m_result_next.value  = rhs;
                m_result_next.status = ST_OK;
            end
        end
        if (finish) begin
            depth_next = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg      <= tok_next;
        res_reg      <= res_next;
        m_result_reg <= m_result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // Checks
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_err_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result.status != ST_OK) |-> (m_result.value == '0))
        else $error("nonzero value with error status");

    a_div_operands: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (depth_reg >= DW'(2) && err_reg == ST_OK && rhs != '0))
        else $error("divide started without valid operands");

    a_sticky_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && err_reg != ST_OK) |=> $stable(depth_reg))
        else $error("stack changed under a pending error");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("accepted token not executed");

endmodule
